>>> rtl/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types, constants and the one's-complement add for the UDP receive
// checker.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_SLOTS   = 4;

  localparam logic [1:0] VERDICT_DELIVERED = 2'd0;
  localparam logic [1:0] VERDICT_TOO_SHORT = 2'd1;
  localparam logic [1:0] VERDICT_BAD_SUM   = 2'd2;
  localparam logic [1:0] VERDICT_NO_PORT   = 2'd3;

  localparam logic [15:0] PROTO_UDP      = 16'd17;
  localparam logic [15:0] HEADER_BYTES   = 16'd8;
  localparam logic [15:0] SUM_ALL_ONES   = 16'hffff;
  localparam logic [15:0] COUNT_MAX      = 16'hffff;
  localparam logic [31:0] ADDR_BROADCAST = 32'hffff_ffff;

  // Operands and header fields of one finished datagram
  typedef struct packed {
    logic        short_dgram;
    logic        csum_present;
    logic [15:0] sum_data;
    logic [15:0] sum_pseudo;
    logic [15:0] pad;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] total_length;
    logic [31:0] dest_addr;
  } fin_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

>>> rtl/urc_if.sv
// ----------------------------------------------------------------------------
// urc_if
// Valid/ready channels of the UDP receive checker: byte items in, verdicts out.
// ----------------------------------------------------------------------------
interface urc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  modport source (output valid, data_byte, last_byte, source_address,
                  destination_address, input ready);
  modport sink (input valid, data_byte, last_byte, source_address,
                destination_address, output ready);
endinterface

interface urc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [1:0]  binding_index;
  logic [15:0] source_port;
  logic [15:0] payload_length;
  logic        send_unreachable;

  modport source (output valid, verdict, binding_index, source_port, payload_length,
                  send_unreachable, input ready);
  modport sink (input valid, verdict, binding_index, source_port, payload_length,
                send_unreachable, output ready);
endinterface

>>> rtl/udp_receive_checker_core.sv
// ----------------------------------------------------------------------------
// udp_receive_checker_core
// UDP checksum check and port demultiplex for received datagrams.
// ----------------------------------------------------------------------------
// Usage:
//   item_in carries one datagram byte per item, header first, with last_byte
//   on the final byte; the IPv4 addresses are sampled with the first byte.
//   result_out carries one verdict item per datagram, produced only by the
//   last byte: delivered (with slot, source port and payload length), too
//   short, bad checksum, or no port (with the unreachable flag).
//   Throughput is one byte per cycle, set by the single-pass state update;
//   a last byte waits while the hand-off register is full. The verdict
//   passes through the input register, hand-off register and result register.
//   The cfg port binds a port to slot cfg_index; write only while idle.
//   Reset clears all bindings and the per-datagram state.
//   When result_out stalls, the result register holds; non-last bytes keep
//   flowing, and a last byte waits in the input register for the hand-off
//   register, so item_in.ready drops only when both later stages are full.
// ----------------------------------------------------------------------------
module udp_receive_checker_core #(
  parameter int NUM_BINDINGS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  urc_in_if.sink                          item_in,
  urc_out_if.source                       result_out,
  input  logic                            cfg_write,
  input  logic [urc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import urc_pkg::*;

  // only the first four slots are addressable
  localparam int NUM_SLOTS = (NUM_BINDINGS < MAX_SLOTS) ? NUM_BINDINGS : MAX_SLOTS;

  logic [15:0] bound_port [NUM_SLOTS];
  fin_t        fin;
  logic        fin_valid;
  logic        fin_ready;

  // binding table
  urc_bind_regs #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_bind (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bound_port (bound_port)
  );

  // byte stage: capture header, accumulate sums
  urc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .fin       (fin),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready)
  );

  // verdict stage: fold, match, register the result
  urc_verdict #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_verdict (
    .clk        (clk),
    .rst        (rst),
    .fin        (fin),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .bound_port (bound_port),
    .result_out (result_out)
  );

endmodule

>>> rtl/urc_bind_regs.sv
// ----------------------------------------------------------------------------
// urc_bind_regs
// Port binding table, written through the configuration port.
// ----------------------------------------------------------------------------
module urc_bind_regs #(
  parameter int NUM_SLOTS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [urc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [15:0]                    bound_port [NUM_SLOTS]
);
  import urc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) bound_port[i] <= 16'd0;
    end else if (cfg_write) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (cfg_index == CFG_INDEX_W'(i)) bound_port[i] <= cfg_data[15:0];
      end
    end
  end

endmodule

>>> rtl/urc_accum.sv
// ----------------------------------------------------------------------------
// urc_accum
// Input register and per-datagram state: header capture, data and
// pseudo-header sums, hand-off of the finished datagram.
// ----------------------------------------------------------------------------
module urc_accum (
  input  logic          clk,
  input  logic          rst,
  urc_in_if.sink        item_in,
  output urc_pkg::fin_t fin,
  output logic          fin_valid,
  input  logic          fin_ready
);
  import urc_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [31:0] in_src;
  logic [31:0] in_dst;
  logic        fire;

  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic [15:0] sport, sport_next;
  logic [15:0] dport, dport_next;
  logic [15:0] total_length, total_length_next;
  logic        csum_present, csum_present_next;
  logic [31:0] src_addr, src_addr_next;
  logic [31:0] dst_addr, dst_addr_next;
  logic [15:0] pseudo_sum, pseudo_sum_next;
  fin_t        fin_next;

  // a last byte needs room in the hand-off register, others never wait
  assign fire          = in_valid && (!in_last || !fin_valid || fin_ready);
  assign item_in.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_byte <= item_in.data_byte;
      in_last <= item_in.last_byte;
      in_src  <= item_in.source_address;
      in_dst  <= item_in.destination_address;
    end
  end

  always_comb begin
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    held_high_byte_next = held_high_byte;
    sport_next          = sport;
    dport_next          = dport;
    total_length_next   = total_length;
    csum_present_next   = csum_present;
    src_addr_next       = src_addr;
    dst_addr_next       = dst_addr;
    pseudo_sum_next     = pseudo_sum;

    // header capture; fold the pseudo-header words in over the header bytes
    case (byte_count)
      16'd0: begin
        src_addr_next         = in_src;
        dst_addr_next         = in_dst;
        pseudo_sum_next       = PROTO_UDP;
        sport_next[15:8]      = in_byte;
      end
      16'd1: begin
        sport_next[7:0]       = in_byte;
        pseudo_sum_next       = oc_add(pseudo_sum, src_addr[31:16]);
      end
      16'd2: begin
        dport_next[15:8]      = in_byte;
        pseudo_sum_next       = oc_add(pseudo_sum, src_addr[15:0]);
      end
      16'd3: begin
        dport_next[7:0]       = in_byte;
        pseudo_sum_next       = oc_add(pseudo_sum, dst_addr[31:16]);
      end
      16'd4: begin
        total_length_next[15:8] = in_byte;
        pseudo_sum_next         = oc_add(pseudo_sum, dst_addr[15:0]);
      end
      16'd5: total_length_next[7:0] = in_byte;
      16'd6: begin
        csum_present_next = csum_present || (in_byte != 8'd0);
        pseudo_sum_next   = oc_add(pseudo_sum, total_length);
      end
      16'd7: csum_present_next = csum_present || (in_byte != 8'd0);
      default: ;
    endcase

    // sum the header and the bytes covered by the length field
    if (byte_count < HEADER_BYTES || byte_count < total_length) begin
      if (!byte_count[0]) begin
        held_high_byte_next = in_byte;
      end else begin
        running_sum_next = oc_add(running_sum, {held_high_byte, in_byte});
      end
    end

    if (byte_count != COUNT_MAX) byte_count_next = byte_count + 16'd1;

    fin_next.short_dgram  = (byte_count_next < HEADER_BYTES) ||
                            (total_length_next < HEADER_BYTES) ||
                            (total_length_next > byte_count_next);
    fin_next.csum_present = csum_present_next;
    fin_next.sum_data     = running_sum_next;
    fin_next.sum_pseudo   = pseudo_sum_next;
    fin_next.pad          = total_length_next[0] ? {held_high_byte_next, 8'h00} : 16'h0000;
    fin_next.source_port  = sport_next;
    fin_next.dest_port    = dport_next;
    fin_next.total_length = total_length_next;
    fin_next.dest_addr    = dst_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      byte_count     <= 16'd0;
      running_sum    <= 16'd0;
      held_high_byte <= 8'd0;
      sport          <= 16'd0;
      dport          <= 16'd0;
      total_length   <= 16'd0;
      csum_present   <= 1'b0;
      src_addr       <= 32'd0;
      dst_addr       <= 32'd0;
      pseudo_sum     <= 16'd0;
    end else if (fire) begin
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
      held_high_byte <= held_high_byte_next;
      sport          <= sport_next;
      dport          <= dport_next;
      total_length   <= total_length_next;
      csum_present   <= csum_present_next;
      src_addr       <= src_addr_next;
      dst_addr       <= dst_addr_next;
      pseudo_sum     <= pseudo_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fire && in_last) begin
      fin_valid <= 1'b1;
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) fin <= fin_next;
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> byte_count == 16'd0)
    else $error("datagram state not cleared after last byte");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled input register lost its item");
`endif

endmodule

>>> rtl/urc_verdict.sv
// ----------------------------------------------------------------------------
// urc_verdict
// Final checksum fold, port match and verdict, held in the result register.
// ----------------------------------------------------------------------------
module urc_verdict #(
  parameter int NUM_SLOTS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  urc_pkg::fin_t fin,
  input  logic          fin_valid,
  output logic          fin_ready,
  input  logic [15:0]   bound_port [NUM_SLOTS],
  urc_out_if.source     result_out
);
  import urc_pkg::*;

  logic [17:0] sum3;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        found;
  logic [1:0]  slot;
  logic [1:0]  verdict_d;
  logic [1:0]  slot_d;
  logic [15:0] sport_d;
  logic [15:0] plen_d;
  logic        unreach_d;
  logic        load;

  assign fin_ready = !result_out.valid || result_out.ready;
  assign load      = fin_valid && fin_ready;

  always_comb begin
    sum3  = {2'b00, fin.sum_data} + {2'b00, fin.sum_pseudo} + {2'b00, fin.pad};
    fold1 = {1'b0, sum3[15:0]} + {15'd0, sum3[17:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};

    // lowest matching slot wins
    found = 1'b0;
    slot  = 2'd0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (bound_port[i] != 16'd0 && bound_port[i] == fin.dest_port) begin
        found = 1'b1;
        slot  = 2'(i);
      end
    end

    verdict_d = VERDICT_DELIVERED;
    slot_d    = 2'd0;
    sport_d   = 16'd0;
    plen_d    = 16'd0;
    unreach_d = 1'b0;
    if (fin.short_dgram) begin
      verdict_d = VERDICT_TOO_SHORT;
    end else begin
      sport_d = fin.source_port;
      if (fin.csum_present && fold2 != SUM_ALL_ONES) begin
        verdict_d = VERDICT_BAD_SUM;
      end else if (found) begin
        verdict_d = VERDICT_DELIVERED;
        slot_d    = slot;
        plen_d    = fin.total_length - HEADER_BYTES;
      end else begin
        verdict_d = VERDICT_NO_PORT;
        unreach_d = (fin.dest_addr != ADDR_BROADCAST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (fin_ready) begin
      result_out.valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out.verdict          <= verdict_d;
      result_out.binding_index    <= slot_d;
      result_out.source_port      <= sport_d;
      result_out.payload_length   <= plen_d;
      result_out.send_unreachable <= unreach_d;
    end
  end

`ifndef SYNTHESIS
  a_short_verdict: assert property (@(posedge clk) disable iff (rst)
    load && fin.short_dgram |=>
      result_out.valid && result_out.verdict == VERDICT_TOO_SHORT)
    else $error("short datagram not reported as too short");

  a_broadcast_quiet: assert property (@(posedge clk) disable iff (rst)
    load && fin.dest_addr == ADDR_BROADCAST |=> !result_out.send_unreachable)
    else $error("unreachable flagged for broadcast datagram");
`endif

endmodule
